// ===== hw/rtl/clp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types, codes and helpers for the command line parser.
// ----------------------------------------------------------------------------
package clp_pkg;

   localparam int SEQ_BITS = 16;

   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_REJECT = 2'd0;
   localparam verdict_type VERDICT_ENABLE = 2'd1;
   localparam verdict_type VERDICT_SIMPLE = 2'd2;

   typedef logic [2:0] phase_type;
   localparam phase_type PH_START  = 3'd0;
   localparam phase_type PH_SECOND = 3'd1;
   localparam phase_type PH_THIRD  = 3'd2;
   localparam phase_type PH_FIELD1 = 3'd3;
   localparam phase_type PH_SEQ    = 3'd4;
   localparam phase_type PH_DEAD   = 3'd5;

   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] POS_LIMIT = 32'd2147483647;
   localparam logic [31:0] NEG_LIMIT = 32'd2147483648;

   // acc * 10 + d, four guard bits flag a 32-bit overflow
   function automatic logic [35:0] mul10_add(input logic [31:0] acc, input logic [3:0] d);
      logic [35:0] acc_ext;
      acc_ext = {4'd0, acc};
      mul10_add = (acc_ext << 3) + (acc_ext << 1) + {32'd0, d};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/command_line_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A line-ending request shows its result on rsp in the cycle after acceptance.
// Throughput: one character per cycle while req_tready is high; each character updates the
// accumulators (multiply by ten and add) in the cycle it is accepted.
// req_tready drops only while a result waits in the output register and rsp_tready is low.
// Reset (synchronous, active high) clears the line state, the opcode and the output valid.
// ----------------------------------------------------------------------------
// command_line_parser_unit
// Parses enable and simple command lines one character at a time and gives
// one verdict per line.
// ----------------------------------------------------------------------------
module command_line_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [1:0] verdict, [33:2] setpoint_out,
                                         // [49:34] sequence_out, [55:50] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_data     // simple_opcode
);

   clp_pkg::phase_type en_phase_ff, en_phase_in;
   clp_pkg::phase_type sm_phase_ff, sm_phase_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [31:0] en_seq_ff, en_seq_in;
   logic [31:0] sm_seq_ff, sm_seq_in;
   logic [1:0]  seen_ff, seen_in;
   logic [23:0] opcode_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   clp_pkg::verdict_type verdict_ff, verdict_in;
   logic [31:0] setpoint_ff, setpoint_in;
   logic [15:0] sequence_ff, sequence_in;

   logic        req_fire;
   logic        is_digit;
   logic [3:0]  digit;
   logic [35:0] mag_next, en_seq_next, sm_seq_next;
   logic        mag_ok, en_seq_ok, sm_seq_ok;
   logic [7:0]  op_char;
   logic        op_ok;
   logic [31:0] limit;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_digit   = (req_tdata >= clp_pkg::CHAR_ZERO) && (req_tdata <= clp_pkg::CHAR_NINE);
   // ASCII digits carry their value in the low nibble
   assign digit      = is_digit ? req_tdata[3:0] : 4'd0;

   assign mag_next    = clp_pkg::mul10_add(mag_ff, digit);
   assign en_seq_next = clp_pkg::mul10_add(en_seq_ff, digit);
   assign sm_seq_next = clp_pkg::mul10_add(sm_seq_ff, digit);
   assign mag_ok      = (mag_next[35:32] == 4'd0);
   assign en_seq_ok   = (en_seq_next[35:32] == 4'd0);
   assign sm_seq_ok   = (sm_seq_next[35:32] == 4'd0);

   assign op_ok = (opcode_ff[23:16] != 8'd0) && (opcode_ff[15:8] != 8'd0)
               && (opcode_ff[7:0] != 8'd0);
   assign limit = neg_ff ? clp_pkg::NEG_LIMIT : clp_pkg::POS_LIMIT;

   always_comb begin
      unique case (sm_phase_ff)
         clp_pkg::PH_START:  op_char = opcode_ff[23:16];
         clp_pkg::PH_SECOND: op_char = opcode_ff[15:8];
         default:            op_char = opcode_ff[7:0];
      endcase
   end

   // line state
   always_comb begin
      en_phase_in = en_phase_ff;
      sm_phase_in = sm_phase_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      en_seq_in   = en_seq_ff;
      sm_seq_in   = sm_seq_ff;
      seen_in     = seen_ff;
      if (req_fire) begin
         if (req_tdata == 8'd0) begin
            // end of line: start over
            en_phase_in = clp_pkg::PH_START;
            sm_phase_in = clp_pkg::PH_START;
            mag_in      = '0;
            neg_in      = 1'b0;
            en_seq_in   = '0;
            sm_seq_in   = '0;
            seen_in     = '0;
         end else begin
            unique case (en_phase_ff)
               clp_pkg::PH_START:
                  en_phase_in = (req_tdata == clp_pkg::CHAR_E) ? clp_pkg::PH_SECOND
                                                               : clp_pkg::PH_DEAD;
               clp_pkg::PH_SECOND:
                  en_phase_in = (req_tdata == clp_pkg::CHAR_N) ? clp_pkg::PH_THIRD
                                                               : clp_pkg::PH_DEAD;
               clp_pkg::PH_THIRD:
                  en_phase_in = (req_tdata == clp_pkg::CHAR_COMMA) ? clp_pkg::PH_FIELD1
                                                                   : clp_pkg::PH_DEAD;
               clp_pkg::PH_FIELD1: begin
                  priority if (is_digit) begin
                     if (mag_ok) begin
                        mag_in     = mag_next[31:0];
                        seen_in[0] = 1'b1;
                     end else begin
                        en_phase_in = clp_pkg::PH_DEAD;
                     end
                  end else if (req_tdata == clp_pkg::CHAR_MINUS && !seen_ff[0] && !neg_ff) begin
                     neg_in = 1'b1;
                  end else if (req_tdata == clp_pkg::CHAR_COMMA && seen_ff[0]) begin
                     if (mag_ff > limit) begin
                        en_phase_in = clp_pkg::PH_DEAD;
                     end else begin
                        en_phase_in = clp_pkg::PH_SEQ;
                        seen_in[0]  = 1'b0;
                     end
                  end else begin
                     en_phase_in = clp_pkg::PH_DEAD;
                  end
               end
               clp_pkg::PH_SEQ: begin
                  if (is_digit && en_seq_ok) begin
                     en_seq_in  = en_seq_next[31:0];
                     seen_in[0] = 1'b1;
                  end else begin
                     en_phase_in = clp_pkg::PH_DEAD;
                  end
               end
               default: en_phase_in = clp_pkg::PH_DEAD;
            endcase

            unique case (sm_phase_ff)
               clp_pkg::PH_START, clp_pkg::PH_SECOND, clp_pkg::PH_THIRD:
                  sm_phase_in = (req_tdata == op_char) ? sm_phase_ff + 3'd1
                                                       : clp_pkg::PH_DEAD;
               clp_pkg::PH_FIELD1:
                  sm_phase_in = (req_tdata == clp_pkg::CHAR_COMMA) ? clp_pkg::PH_SEQ
                                                                   : clp_pkg::PH_DEAD;
               clp_pkg::PH_SEQ: begin
                  if (is_digit && sm_seq_ok) begin
                     sm_seq_in  = sm_seq_next[31:0];
                     seen_in[1] = 1'b1;
                  end else begin
                     sm_phase_in = clp_pkg::PH_DEAD;
                  end
               end
               default: sm_phase_in = clp_pkg::PH_DEAD;
            endcase
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      setpoint_in  = setpoint_ff;
      sequence_in  = sequence_ff;
      if (req_fire && req_tdata == 8'd0) begin
         rsp_valid_in = 1'b1;
         verdict_in   = clp_pkg::VERDICT_REJECT;
         setpoint_in  = '0;
         sequence_in  = '0;
         priority if (en_phase_ff == clp_pkg::PH_SEQ && seen_ff[0]
                      && (en_seq_ff >> clp_pkg::SEQ_BITS) == 32'd0) begin
            verdict_in  = clp_pkg::VERDICT_ENABLE;
            setpoint_in = neg_ff ? (32'd0 - mag_ff) : mag_ff;
            sequence_in = en_seq_ff[15:0];
         end else if (op_ok && sm_phase_ff == clp_pkg::PH_SEQ && seen_ff[1]
                      && (sm_seq_ff >> clp_pkg::SEQ_BITS) == 32'd0) begin
            verdict_in  = clp_pkg::VERDICT_SIMPLE;
            sequence_in = sm_seq_ff[15:0];
         end else begin
            verdict_in = clp_pkg::VERDICT_REJECT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_phase_ff  <= clp_pkg::PH_START;
         sm_phase_ff  <= clp_pkg::PH_START;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         en_seq_ff    <= '0;
         sm_seq_ff    <= '0;
         seen_ff      <= '0;
         opcode_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         en_phase_ff  <= en_phase_in;
         sm_phase_ff  <= sm_phase_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         en_seq_ff    <= en_seq_in;
         sm_seq_ff    <= sm_seq_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            opcode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff  <= verdict_in;
      setpoint_ff <= setpoint_in;
      sequence_ff <= sequence_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, sequence_ff, setpoint_ff, verdict_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/clp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clp_checker
// Port-level checks on the command line parser, bound to the top level.
// ----------------------------------------------------------------------------
module clp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [23:0] csr_data
);

   logic [1:0] verdict;
   assign verdict = rsp_tdata[1:0];

   // a line end always yields a result in the next cycle
   a_line_end_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata == 8'd0 |=> rsp_tvalid)
      else $error("line end gave no result");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_setpoint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && verdict != clp_pkg::VERDICT_ENABLE |-> rsp_tdata[33:2] == 32'd0)
      else $error("setpoint set on a non-enable result");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> verdict != 2'd3
         && (verdict != clp_pkg::VERDICT_REJECT || rsp_tdata[55:34] == 22'd0))
      else $error("bad verdict or reject carries data");

   // no result without a line end unless one is being held
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && req_tdata == 8'd0) |=> !rsp_tvalid)
      else $error("result appeared without a line end");

   logic unused_csr;
   assign unused_csr = csr_valid ^ csr_ready ^ (^csr_data);

endmodule

bind command_line_parser_unit clp_checker u_clp_checker (.*);
`default_nettype wire
